### rtl/bracket_partner_matcher_unit_assert.svh
// Assertion macros for the bracket partner matcher
`ifndef BRACKET_PARTNER_MATCHER_UNIT_ASSERT_SVH
`define BRACKET_PARTNER_MATCHER_UNIT_ASSERT_SVH

// same-cycle implication
`define BPM_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/bpm_pkg.sv
`default_nettype none

package bpm_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int QUEUE_DEPTH = 4;
  localparam int MAX_RESULTS = 3;

  localparam logic [15:0] CODE_OPEN_ROUND   = 16'd40;
  localparam logic [15:0] CODE_OPEN_SQUARE  = 16'd91;
  localparam logic [15:0] CODE_OPEN_CURLY   = 16'd123;
  localparam logic [15:0] CODE_CLOSE_ROUND  = 16'd41;
  localparam logic [15:0] CODE_CLOSE_SQUARE = 16'd93;
  localparam logic [15:0] CODE_CLOSE_CURLY  = 16'd125;

  localparam logic signed [16:0] PARTNER_NONE = -17'sd1;
  localparam logic [8:0] DEPTH_LIMIT_RESET = 9'd256;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_DEEP  = 2'd1,
    ST_UNMATCHED = 2'd2,
    ST_UNCLOSED  = 2'd3
  } status_t;

  typedef struct packed {
    logic [15:0]        entry_index;
    logic signed [16:0] partner_index;
    status_t            status;
    logic [8:0]         open_count;
    logic               last_of_run;
  } result_t;

endpackage

`default_nettype wire

### rtl/bracket_partner_matcher_unit.sv
// Bracket partner matcher.
// Input channel (in_valid / in_stall) takes one token word per unstalled cycle: code,
// index and first/last flags. Output channel (out_valid / out_stall) gives
// partner words: an opener or plain token gives one word, a matched closer
// gives two (closer->opener, then opener->closer), a refused opener or an
// unmatched closer gives one error word, and a last token with brackets
// still open adds one unclosed word. last_of_run marks each token's final word.
// An accepted token is held in the input register and its words are then
// written to the result queue, from which they leave. Throughput: one token
// per cycle while each token gives one word and out_stall stays low; the
// output port emits one word per cycle while out_stall is low.
// The open stack sits in a memory with one write port and one registered
// read port; the current top is forwarded so a pop can follow a push in the
// next cycle. A four-word result queue decouples the output: the input keeps
// flowing while a finished word waits, and in_stall rises only when the
// queue cannot take three more words.
// depth_limit is written through cfg_wr_en / cfg_wr_data; the user must write it only while idle (not enforced).
// Reset (synchronous) empties the stack and queue, sets depth_limit to 256.
`default_nettype none

`include "bracket_partner_matcher_unit_assert.svh"

module bracket_partner_matcher_unit #(
  parameter int STACK_DEPTH = bpm_pkg::STACK_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wr_en,
  input  wire logic [8:0]         cfg_wr_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [15:0]        token_code,
  input  wire logic [15:0]        token_index,
  input  wire logic               first_token,
  input  wire logic               last_token,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [15:0]             entry_index,
  output logic signed [16:0]      partner_index,
  output logic [1:0]              status,
  output logic [8:0]              open_count,
  output logic                    last_of_run
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int LW = (CW > 9) ? CW : 9;
  localparam int QD = bpm_pkg::QUEUE_DEPTH;
  localparam int QAW = $clog2(QD);
  localparam int QCW = $clog2(QD + 1);
  localparam int NR = bpm_pkg::MAX_RESULTS;
  localparam logic [LW-1:0] DEPTH_CAP = LW'(STACK_DEPTH);

  logic [8:0] depth_limit;

  logic        s_valid;
  logic [15:0] s_code;
  logic [15:0] s_index;
  logic        s_first;
  logic        s_last;
  logic        s_load;
  logic        s_move;

  logic [15:0] stack_mem [STACK_DEPTH];
  logic [15:0] rd_data;
  logic        byp;
  logic [15:0] byp_data;
  logic [15:0] top_val;
  logic [AW-1:0] rd_addr;

  logic [CW-1:0] top;
  logic [CW-1:0] top_next;
  logic [CW-1:0] top_base;
  logic [CW-1:0] top_new;
  logic          push;

  bpm_pkg::result_t res [NR];
  logic [1:0]       res_n;

  bpm_pkg::result_t q [QD];
  logic [QAW-1:0]   q_wp;
  logic [QAW-1:0]   q_rp;
  logic [QCW-1:0]   q_count;
  logic [QCW-1:0]   q_count_next;
  logic             q_pop;

  assign top_val = byp ? byp_data : rd_data;

  assign s_move   = s_valid && (q_count <= QCW'(QD - NR));
  assign in_stall = s_valid && !s_move;
  assign s_load   = in_valid && !in_stall;

  always_comb begin
    logic [LW-1:0] limit_eff;
    logic          is_open;
    logic          is_close;
    logic [1:0]    nb;
    bpm_pkg::result_t base0;
    bpm_pkg::result_t base1;
    bpm_pkg::result_t unc;
    limit_eff = (LW'(depth_limit) > DEPTH_CAP) ? DEPTH_CAP : LW'(depth_limit);
    is_open = (s_code == bpm_pkg::CODE_OPEN_ROUND) ||
              (s_code == bpm_pkg::CODE_OPEN_SQUARE) ||
              (s_code == bpm_pkg::CODE_OPEN_CURLY);
    is_close = (s_code == bpm_pkg::CODE_CLOSE_ROUND) ||
               (s_code == bpm_pkg::CODE_CLOSE_SQUARE) ||
               (s_code == bpm_pkg::CODE_CLOSE_CURLY);
    top_base = s_first ? '0 : top;
    top_new  = top_base;
    push     = 1'b0;
    nb       = 2'd1;

    base0.entry_index   = s_index;
    base0.partner_index = bpm_pkg::PARTNER_NONE;
    base0.status        = bpm_pkg::ST_OK;
    base0.open_count    = 9'(top_base);
    base0.last_of_run   = 1'b0;
    base1               = base0;

    if (is_open) begin
      if (LW'(top_base) >= limit_eff) begin
        base0.status = bpm_pkg::ST_TOO_DEEP;
      end else begin
        push             = 1'b1;
        top_new          = top_base + CW'(1);
        base0.open_count = 9'(top_new);
      end
    end else if (is_close) begin
      if (top_base == '0) begin
        base0.status = bpm_pkg::ST_UNMATCHED;
      end else begin
        top_new             = top_base - CW'(1);
        base0.partner_index = $signed({1'b0, top_val});
        base0.open_count    = 9'(top_new);
        base1.entry_index   = top_val;
        base1.partner_index = $signed({1'b0, s_index});
        base1.open_count    = 9'(top_new);
        nb                  = 2'd2;
      end
    end

    unc               = base0;
    unc.partner_index = bpm_pkg::PARTNER_NONE;
    unc.entry_index   = s_index;
    unc.status        = bpm_pkg::ST_UNCLOSED;
    unc.open_count    = 9'(top_new);

    res[0] = base0;
    res[1] = base1;
    res[2] = base1;
    res_n  = nb;
    if (s_last && top_new != '0) begin
      if (nb == 2'd1) begin
        res[1] = unc;
      end else begin
        res[2] = unc;
      end
      res_n = nb + 2'd1;
    end

    case (res_n)
      2'd1:    res[0].last_of_run = 1'b1;
      2'd2:    res[1].last_of_run = 1'b1;
      2'd3:    res[2].last_of_run = 1'b1;
      default: res[0].last_of_run = 1'b1;
    endcase
  end

  assign top_next = s_move ? top_new : top;
  assign rd_addr  = AW'(top_next - CW'(1));

  // hold the stack store; write on push, read the new top every cycle
  always_ff @(posedge clk) begin
    if (s_move && push) begin
      stack_mem[top_base[AW-1:0]] <= s_index;
    end
    rd_data  <= stack_mem[rd_addr];
    byp_data <= s_index;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byp <= 1'b0;
      top <= '0;
    end else begin
      byp <= s_move && push;
      top <= top_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_limit <= bpm_pkg::DEPTH_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      depth_limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else begin
      s_valid <= s_load || (s_valid && !s_move);
    end
  end

  always_ff @(posedge clk) begin
    if (s_load) begin
      s_code  <= token_code;
      s_index <= token_index;
      s_first <= first_token;
      s_last  <= last_token;
    end
  end

  assign q_pop = out_valid && !out_stall;
  assign q_count_next = q_count + (s_move ? QCW'(res_n) : '0) - (q_pop ? QCW'(1) : '0);

  always_ff @(posedge clk) begin
    if (s_move) begin
      for (int k = 0; k < NR; k++) begin
        if (k < int'(res_n)) begin
          q[QAW'(q_wp + QAW'(k))] <= res[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wp    <= '0;
      q_rp    <= '0;
      q_count <= '0;
    end else begin
      if (s_move) begin
        q_wp <= q_wp + QAW'(res_n);
      end
      if (q_pop) begin
        q_rp <= q_rp + QAW'(1);
      end
      q_count <= q_count_next;
    end
  end

  assign out_valid     = (q_count != '0);
  assign entry_index   = q[q_rp].entry_index;
  assign partner_index = q[q_rp].partner_index;
  assign status        = q[q_rp].status;
  assign open_count    = q[q_rp].open_count;
  assign last_of_run   = q[q_rp].last_of_run;

  `BPM_ASSERT_IMPLIES(a_queue_bound, 1'b1, q_count <= QCW'(QD), "result queue overflow")
  `BPM_ASSERT_IMPLIES(a_stall_on_full, s_valid && (q_count > QCW'(QD - NR)), in_stall,
                      "stage moved into a full queue")
  `BPM_ASSERT_IMPLIES(a_unclosed_count, out_valid && (status == bpm_pkg::ST_UNCLOSED),
                      open_count != 9'd0, "unclosed word with empty stack")
  `BPM_ASSERT_NEXT(a_push_raises_top, s_move && push, top != '0, "push left the stack empty")

endmodule

`default_nettype wire

### test/partner_word_checker.sv
`timescale 1ns / 1ps

module partner_word_checker
  import bpm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [8:0]         cfg_wr_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [15:0]        token_code,
  input  logic [15:0]        token_index,
  input  logic               first_token,
  input  logic               last_token,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [15:0]        entry_index,
  input  logic signed [16:0] partner_index,
  input  logic [1:0]         status,
  input  logic [8:0]         open_count,
  input  logic               last_of_run,
  output int                 mismatch_count,
  output int                 pending_words
);

  result_t     expected_words[$];
  logic [15:0] open_positions [STACK_DEPTH];
  int unsigned depth;
  logic [8:0]  limit;

  function automatic result_t make_word(input logic [15:0] entry,
                                        input logic signed [16:0] partner,
                                        input status_t st);
    result_t w;
    w.entry_index   = entry;
    w.partner_index = partner;
    w.status        = st;
    w.open_count    = 9'(depth);
    w.last_of_run   = 1'b0;
    return w;
  endfunction

  function automatic void predict_token(input logic [15:0] code, input logic [15:0] pos,
                                        input logic first, input logic last);
    result_t     batch [MAX_RESULTS];
    int          n;
    int          k;
    int unsigned cap;
    logic [15:0] opener;
    n = 0;
    cap = (limit > STACK_DEPTH) ? STACK_DEPTH : limit;
    if (first) depth = 0;
    if (code == CODE_OPEN_ROUND || code == CODE_OPEN_SQUARE || code == CODE_OPEN_CURLY) begin
      if (depth >= cap) begin
        batch[n] = make_word(pos, PARTNER_NONE, ST_TOO_DEEP);
        n = n + 1;
      end else begin
        open_positions[depth] = pos;
        depth = depth + 1;
        batch[n] = make_word(pos, PARTNER_NONE, ST_OK);
        n = n + 1;
      end
    end else if (code == CODE_CLOSE_ROUND || code == CODE_CLOSE_SQUARE ||
                 code == CODE_CLOSE_CURLY) begin
      if (depth == 0) begin
        batch[n] = make_word(pos, PARTNER_NONE, ST_UNMATCHED);
        n = n + 1;
      end else begin
        depth = depth - 1;
        opener = open_positions[depth];
        batch[n] = make_word(pos, {1'b0, opener}, ST_OK);
        batch[n + 1] = make_word(opener, {1'b0, pos}, ST_OK);
        n = n + 2;
      end
    end else begin
      batch[n] = make_word(pos, PARTNER_NONE, ST_OK);
      n = n + 1;
    end
    if (last && depth != 0) begin
      batch[n] = make_word(pos, PARTNER_NONE, ST_UNCLOSED);
      n = n + 1;
    end
    batch[n - 1].last_of_run = 1'b1;
    for (k = 0; k < n; k++) expected_words.push_back(batch[k]);
  endfunction

  function automatic void report(input string field, input longint want, input longint got);
    $error("%s: expected %0d, actual %0d", field, want, got);
    mismatch_count = mismatch_count + 1;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      expected_words.delete();
      depth = 0;
      limit = DEPTH_LIMIT_RESET;
      mismatch_count = 0;
    end else begin
      if (cfg_wr_en) limit = cfg_wr_data;
      if (in_valid && !in_stall)
        predict_token(token_code, token_index, first_token, last_token);
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("word with nothing expected: entry_index %0d, partner_index %0d",
                 entry_index, partner_index);
          mismatch_count = mismatch_count + 1;
        end else begin
          want = expected_words.pop_front();
          if (entry_index !== want.entry_index)
            report("entry_index", want.entry_index, entry_index);
          if (partner_index !== want.partner_index)
            report("partner_index", want.partner_index, partner_index);
          if (status !== want.status)
            report("status", want.status, status);
          if (open_count !== want.open_count)
            report("open_count", want.open_count, open_count);
          if (last_of_run !== want.last_of_run)
            report("last_of_run", want.last_of_run, last_of_run);
        end
      end
    end
    pending_words <= expected_words.size();
  end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import bpm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_wr_en;
  logic [8:0]         cfg_wr_data;
  logic               in_valid;
  logic               in_stall;
  logic [15:0]        token_code;
  logic [15:0]        token_index;
  logic               first_token;
  logic               last_token;
  logic               out_valid;
  logic               out_stall;
  logic [15:0]        entry_index;
  logic signed [16:0] partner_index;
  logic [1:0]         status;
  logic [8:0]         open_count;
  logic               last_of_run;

  int mismatches;
  int pending_words;
  int cycle_count = 0;
  int stall_left = 0;
  int stall_pct;
  logic calm;
  int gap_pct;

  bracket_partner_matcher_unit dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .token_code(token_code), .token_index(token_index),
    .first_token(first_token), .last_token(last_token),
    .out_valid(out_valid), .out_stall(out_stall),
    .entry_index(entry_index), .partner_index(partner_index),
    .status(status), .open_count(open_count), .last_of_run(last_of_run)
  );

  partner_word_checker watch (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .token_code(token_code), .token_index(token_index),
    .first_token(first_token), .last_token(last_token),
    .out_valid(out_valid), .out_stall(out_stall),
    .entry_index(entry_index), .partner_index(partner_index),
    .status(status), .open_count(open_count), .last_of_run(last_of_run),
    .mismatch_count(mismatches), .pending_words(pending_words)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic [15:0] opener_code();
    case ($urandom_range(0, 2))
      0: return CODE_OPEN_ROUND;
      1: return CODE_OPEN_SQUARE;
      default: return CODE_OPEN_CURLY;
    endcase
  endfunction

  function automatic logic [15:0] closer_code();
    case ($urandom_range(0, 2))
      0: return CODE_CLOSE_ROUND;
      1: return CODE_CLOSE_SQUARE;
      default: return CODE_CLOSE_CURLY;
    endcase
  endfunction

  task automatic send_token(input logic [15:0] code, input logic [15:0] pos,
                            input logic first, input logic last);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    token_code <= code;
    token_index <= pos;
    first_token <= first;
    last_token <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [8:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_stream(input int n_tokens, input int open_pct, input int close_pct);
    logic [15:0] pos;
    logic [15:0] code;
    logic first;
    logic last;
    int r;
    int k;
    pos = 16'($urandom);
    for (k = 0; k < n_tokens; k++) begin
      r = $urandom_range(0, 99);
      if (r < open_pct) code = opener_code();
      else if (r < open_pct + close_pct) code = closer_code();
      else code = 16'($urandom);
      first = (k == 0);
      last = (k == n_tokens - 1);
      if ($urandom_range(0, 99) < 3) first = ~first;
      if ($urandom_range(0, 99) < 3) last = ~last;
      send_token(code, pos, first, last);
      pos = pos + 16'd1;
    end
  endtask

  task automatic send_noise(input int n_tokens);
    logic [15:0] code;
    int k;
    for (k = 0; k < n_tokens; k++) begin
      case ($urandom_range(0, 3))
        0: code = opener_code();
        1: code = closer_code();
        default: code = 16'($urandom);
      endcase
      send_token(code, 16'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    logic [8:0]  phase_limits [6];
    logic [15:0] pos;
    int p;
    int budget;
    int len;
    int k;

    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    in_valid <= 1'b0;
    token_code <= '0;
    token_index <= '0;
    first_token <= 1'b0;
    last_token <= 1'b0;
    stall_pct <= 20;
    calm <= 1'b0;
    gap_pct = 20;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_token(16'h0000, 16'd0, 1'b1, 1'b0);
    send_token(CODE_CLOSE_ROUND, 16'd1, 1'b0, 1'b0);
    send_token(CODE_OPEN_ROUND, 16'd2, 1'b0, 1'b0);
    send_token(CODE_OPEN_SQUARE, 16'd3, 1'b0, 1'b0);
    send_token(CODE_OPEN_CURLY, 16'd4, 1'b0, 1'b0);
    send_token(CODE_CLOSE_SQUARE, 16'd5, 1'b0, 1'b0);
    send_token(16'hFFFF, 16'd6, 1'b0, 1'b0);
    send_token(CODE_CLOSE_CURLY, 16'd7, 1'b0, 1'b0);
    send_token(CODE_CLOSE_ROUND, 16'd8, 1'b0, 1'b1);
    send_token(CODE_OPEN_ROUND, 16'hFFFF, 1'b1, 1'b1);
    send_token(CODE_CLOSE_ROUND, 16'd0, 1'b1, 1'b0);
    send_token(CODE_OPEN_ROUND - 16'd1, 16'd10, 1'b0, 1'b0);
    send_token(CODE_CLOSE_ROUND + 16'd1, 16'd11, 1'b0, 1'b0);
    send_token(CODE_OPEN_SQUARE + 16'd1, 16'd12, 1'b0, 1'b0);
    send_token(CODE_CLOSE_CURLY + 16'd1, 16'd13, 1'b0, 1'b0);
    send_token(CODE_OPEN_ROUND, 16'd20, 1'b0, 1'b0);
    send_token(CODE_OPEN_ROUND, 16'd21, 1'b0, 1'b0);
    send_token(CODE_CLOSE_ROUND, 16'd22, 1'b0, 1'b1);

    wait_idle();
    write_limit(9'd0);
    send_token(CODE_OPEN_ROUND, 16'd30, 1'b1, 1'b0);
    send_token(CODE_CLOSE_CURLY, 16'd31, 1'b0, 1'b0);
    send_token(CODE_OPEN_CURLY, 16'd32, 1'b0, 1'b1);

    wait_idle();
    write_limit(9'd2);
    send_token(CODE_OPEN_ROUND, 16'd40, 1'b1, 1'b0);
    send_token(CODE_OPEN_SQUARE, 16'd41, 1'b0, 1'b0);
    send_token(CODE_OPEN_CURLY, 16'd42, 1'b0, 1'b1);
    send_token(CODE_CLOSE_SQUARE, 16'd43, 1'b0, 1'b0);
    send_token(CODE_CLOSE_ROUND, 16'd44, 1'b0, 1'b1);

    phase_limits[0] = 9'd256;
    phase_limits[1] = 9'd3;
    phase_limits[2] = 9'd1;
    phase_limits[3] = 9'($urandom_range(4, 40));
    phase_limits[4] = 9'd0;
    phase_limits[5] = 9'd12;
    for (p = 0; p < 6; p++) begin
      wait_idle();
      write_limit(phase_limits[p]);
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 10;
        default: gap_pct = 35;
      endcase
      case ($urandom_range(0, 2))
        0: stall_pct <= 0;
        1: stall_pct <= 10;
        default: stall_pct <= 35;
      endcase
      budget = 4;
      while (budget > 0) begin
        len = $urandom_range(2, 5);
        run_stream(len, 45, 35);
        budget = budget - len;
      end
      send_noise(2);
    end

    wait_idle();
    write_limit(9'd511);
    gap_pct = 10;
    stall_pct <= 10;
    pos = 16'($urandom);
    for (k = 0; k < STACK_DEPTH + 1; k++) begin
      send_token(opener_code(), pos, k == 0, 1'b0);
      pos = pos + 16'd1;
    end
    for (k = 0; k < 3; k++) begin
      send_token(closer_code(), pos, 1'b0, k == 2);
      pos = pos + 16'd1;
    end

    wait_idle();
    write_limit(9'd5);
    calm <= 1'b1;
    budget = 8;
    while (budget > 0) begin
      len = $urandom_range(2, 5);
      run_stream(len, 45, 35);
      budget = budget - len;
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_words == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
